FILE: sv/p1305_pkg.sv
package p1305_pkg;

   localparam int NUM_LIMBS = 5;
   localparam int LIMB_W    = 26;     // radix 2^26 limb
   localparam int ACC_W     = 27;     // stored accumulator limb, one spare bit
   localparam int OP_W      = 28;     // accumulator limb plus message limb
   localparam int COEF_W    = 29;     // r limb or 5*r limb
   localparam int PROD_W    = OP_W + COEF_W;
   localparam int SUM_W     = 60;     // five products plus carry
   localparam int CARRY_W   = SUM_W - LIMB_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [4:0] BLOCK_BYTES = 5'd16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_R_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_R_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_S_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_S_HIGH = 3'd3;

   // r clamp masks per limb
   localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
   localparam logic [LIMB_W-1:0] CLAMP_R1  = 26'h3ffff03;
   localparam logic [LIMB_W-1:0] CLAMP_R2  = 26'h3ffc0ff;
   localparam logic [LIMB_W-1:0] CLAMP_R3  = 26'h3f03fff;
   localparam logic [LIMB_W-1:0] CLAMP_R4  = 26'h00fffff;

   typedef logic [2:0] row_type;
   localparam row_type LAST_ROW = row_type'(NUM_LIMBS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_FIX,
      ST_FIN_A,
      ST_FIN_B,
      ST_FIN_C
   } state_type;

   typedef struct packed {
      logic load;        // latch operands, r and 5r
      logic mul_en;      // one product row
      logic sum_en;      // sum previous row, shift limb into accumulator
      logic sum_first;   // row 0: no incoming carry
      logic fix;         // fold top carry back into limbs 0 and 1
      logic fin_a;       // carry pass, clear accumulator
      logic fin_b;       // conditional subtract of p, pack to 128 bits
      logic out_load;    // add s, load tag register
   } p1305_cmd_type;

endpackage

FILE: sv/p1305_ctrl.sv
module p1305_ctrl import p1305_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [4:0]    req_valid_bytes,
   input  logic          req_last_block,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output p1305_cmd_type cmd
);

   state_type state_ff, state_in;
   row_type   row_ff, row_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_valid_bytes != 5'd0) state_in = ST_MUL;
               else if (req_last_block)     state_in = ST_FIN_A;
            end
         end
         ST_MUL: begin
            if (row_ff == LAST_ROW) state_in = ST_SUM;
         end
         ST_SUM:   state_in = ST_FIX;
         ST_FIX:   state_in = last_ff ? ST_FIN_A : ST_IDLE;
         ST_FIN_A: state_in = ST_FIN_B;
         ST_FIN_B: state_in = ST_FIN_C;
         ST_FIN_C: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign row_in       = (state_ff == ST_MUL) ? row_type'(row_ff + 3'd1) : '0;
   assign last_in      = accept ? req_last_block : last_ff;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:  cmd.load = req_valid;
         ST_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.sum_en    = (row_ff != '0);
            cmd.sum_first = (row_ff == row_type'(1));
         end
         ST_SUM:   cmd.sum_en   = 1'b1;
         ST_FIX:   cmd.fix      = 1'b1;
         ST_FIN_A: cmd.fin_a    = 1'b1;
         ST_FIN_B: cmd.fin_b    = 1'b1;
         ST_FIN_C: cmd.out_load = out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/p1305_dpath.sv
module p1305_dpath import p1305_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic [63:0]          req_block_low,
   input  logic [63:0]          req_block_high,
   input  logic [4:0]           req_valid_bytes,
   input  p1305_cmd_type        cmd,
   output logic [63:0]          rsp_tag_low,
   output logic [63:0]          rsp_tag_high
);

   logic [63:0] key_r_low_ff, key_r_high_ff, key_s_low_ff, key_s_high_ff;

   logic [ACC_W-1:0]   acc_ff   [NUM_LIMBS];
   logic [OP_W-1:0]    op_ff    [NUM_LIMBS];
   logic [OP_W-1:0]    op_in    [NUM_LIMBS];
   logic [COEF_W-1:0]  coef_ff  [NUM_LIMBS];
   logic [COEF_W-1:0]  coef_in  [NUM_LIMBS];
   logic [LIMB_W-1:0]  rq_ff    [NUM_LIMBS-1];
   logic [PROD_W-1:0]  prod_ff  [NUM_LIMBS];
   logic [PROD_W-1:0]  prod_in  [NUM_LIMBS];
   logic [CARRY_W-1:0] carry_ff;
   logic [ACC_W-1:0]   fin_ff   [NUM_LIMBS];
   logic [ACC_W-1:0]   fin_in   [NUM_LIMBS];
   logic [127:0]       w_ff, w_in;
   logic [127:0]       tag_ff;

   logic [4:0]         n_bytes;
   logic [127:0]       raw_blk;
   logic [127:0]       pad_blk;
   logic               top_bit;
   logic [LIMB_W-1:0]  m_limb   [NUM_LIMBS];
   logic [127:0]       key_r;
   logic [LIMB_W-1:0]  r_limb   [NUM_LIMBS];
   logic [COEF_W-1:0]  r5_limb  [NUM_LIMBS];
   logic [SUM_W-1:0]   d_sum;
   logic [37:0]        fix_t0;
   logic [ACC_W-1:0]   fix_h1;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_r_low_ff  <= '0;
         key_r_high_ff <= '0;
         key_s_low_ff  <= '0;
         key_s_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_R_LOW:  key_r_low_ff  <= csr_wdata;
            CSR_KEY_R_HIGH: key_r_high_ff <= csr_wdata;
            CSR_KEY_S_LOW:  key_s_low_ff  <= csr_wdata;
            CSR_KEY_S_HIGH: key_s_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Block padding: 0x01 after the valid bytes, bit 128 only for a full block
   always_comb begin
      n_bytes = (req_valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : req_valid_bytes;
      raw_blk = {req_block_high, req_block_low};
      for (int b = 0; b < 16; b++) begin
         if (5'(b) < n_bytes)       pad_blk[8*b +: 8] = raw_blk[8*b +: 8];
         else if (5'(b) == n_bytes) pad_blk[8*b +: 8] = 8'h01;
         else                       pad_blk[8*b +: 8] = 8'h00;
      end
      top_bit   = (n_bytes == BLOCK_BYTES);
      m_limb[0] = pad_blk[25:0];
      m_limb[1] = pad_blk[51:26];
      m_limb[2] = pad_blk[77:52];
      m_limb[3] = pad_blk[103:78];
      m_limb[4] = {1'b0, top_bit, pad_blk[127:104]};
   end

   // r clamp and 5*r
   always_comb begin
      key_r     = {key_r_high_ff, key_r_low_ff};
      r_limb[0] = key_r[25:0]   & LIMB_MASK;
      r_limb[1] = key_r[51:26]  & CLAMP_R1;
      r_limb[2] = key_r[77:52]  & CLAMP_R2;
      r_limb[3] = key_r[103:78] & CLAMP_R3;
      r_limb[4] = {2'b00, key_r[127:104]} & CLAMP_R4;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         r5_limb[i] = {1'b0, r_limb[i], 2'b00} + COEF_W'(r_limb[i]);
         op_in[i]   = OP_W'(acc_ff[i]) + OP_W'(m_limb[i]);
      end
   end

   // Coefficient row k, column j: r[k-j] for j <= k, else 5*r[k-j+5].
   // Row 0 is {r0, 5r4, 5r3, 5r2, 5r1}; each next row shifts right and takes r[k+1].
   always_comb begin
      coef_in[0] = COEF_W'(rq_ff[0]);
      for (int j = 1; j < NUM_LIMBS; j++) coef_in[j] = coef_ff[j-1];
      for (int j = 0; j < NUM_LIMBS; j++) prod_in[j] = op_ff[j] * coef_ff[j];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_in;
         coef_ff[0] <= COEF_W'(r_limb[0]);
         for (int j = 1; j < NUM_LIMBS; j++) begin
            coef_ff[j]  <= r5_limb[NUM_LIMBS-j];
            rq_ff[j-1]  <= r_limb[j];
         end
      end else if (cmd.mul_en) begin
         coef_ff <= coef_in;
         for (int j = 0; j < NUM_LIMBS - 2; j++) rq_ff[j] <= rq_ff[j+1];
      end
      if (cmd.mul_en) prod_ff <= prod_in;
   end

   // Row sum with carry from the previous row
   always_comb begin
      d_sum = cmd.sum_first ? '0 : SUM_W'(carry_ff);
      for (int j = 0; j < NUM_LIMBS; j++) d_sum = d_sum + SUM_W'(prod_ff[j]);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_en) carry_ff <= d_sum[SUM_W-1:LIMB_W];
   end

   // Top carry times 5 goes back into limb 0, then one more carry into limb 1
   assign fix_t0 = 38'(acc_ff[0]) + 38'({carry_ff, 2'b00}) + 38'(carry_ff);
   assign fix_h1 = acc_ff[1] + ACC_W'(fix_t0[37:LIMB_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LIMBS; i++) acc_ff[i] <= '0;
      end else if (cmd.sum_en) begin
         for (int i = 0; i < NUM_LIMBS - 1; i++) acc_ff[i] <= acc_ff[i+1];
         acc_ff[NUM_LIMBS-1] <= ACC_W'(d_sum[LIMB_W-1:0]);
      end else if (cmd.fix) begin
         acc_ff[0] <= ACC_W'(fix_t0[LIMB_W-1:0]);
         acc_ff[1] <= fix_h1;
      end else if (cmd.fin_a) begin
         for (int i = 0; i < NUM_LIMBS; i++) acc_ff[i] <= '0;
      end
   end

   // Final carry pass
   always_comb begin
      logic [31:0] a0, a1, a2, a3, a4;
      a0 = 32'(acc_ff[0]);
      a1 = 32'(acc_ff[1]);
      a2 = 32'(acc_ff[2]);
      a3 = 32'(acc_ff[3]);
      a4 = 32'(acc_ff[4]);
      a2 = a2 + (a1 >> 26); a1 = a1 & 32'(LIMB_MASK);
      a3 = a3 + (a2 >> 26); a2 = a2 & 32'(LIMB_MASK);
      a4 = a4 + (a3 >> 26); a3 = a3 & 32'(LIMB_MASK);
      a0 = a0 + (a4 >> 26) * 32'd5; a4 = a4 & 32'(LIMB_MASK);
      a1 = a1 + (a0 >> 26); a0 = a0 & 32'(LIMB_MASK);
      fin_in[0] = a0[ACC_W-1:0];
      fin_in[1] = a1[ACC_W-1:0];
      fin_in[2] = a2[ACC_W-1:0];
      fin_in[3] = a3[ACC_W-1:0];
      fin_in[4] = a4[ACC_W-1:0];
   end

   // h - p when h >= p, then pack to 128 bits
   always_comb begin
      logic [31:0] h0, h1, h2, h3, h4;
      logic [31:0] g0, g1, g2, g3, g4;
      h0 = 32'(fin_ff[0]);
      h1 = 32'(fin_ff[1]);
      h2 = 32'(fin_ff[2]);
      h3 = 32'(fin_ff[3]);
      h4 = 32'(fin_ff[4]);
      g0 = h0 + 32'd5;
      g1 = h1 + (g0 >> 26); g0 = g0 & 32'(LIMB_MASK);
      g2 = h2 + (g1 >> 26); g1 = g1 & 32'(LIMB_MASK);
      g3 = h3 + (g2 >> 26); g2 = g2 & 32'(LIMB_MASK);
      g4 = h4 + (g3 >> 26) - 32'h0400_0000; g3 = g3 & 32'(LIMB_MASK);
      if (!g4[31]) begin
         h0 = g0;
         h1 = g1;
         h2 = g2;
         h3 = g3;
         h4 = g4;
      end
      w_in[31:0]   = h0 | (h1 << 26);
      w_in[63:32]  = (h1 >> 6) | (h2 << 20);
      w_in[95:64]  = (h2 >> 12) | (h3 << 14);
      w_in[127:96] = (h3 >> 18) | (h4 << 8);
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_a)    fin_ff <= fin_in;
      if (cmd.fin_b)    w_ff   <= w_in;
      if (cmd.out_load) tag_ff <= w_ff + {key_s_high_ff, key_s_low_ff};
   end

   assign rsp_tag_low  = tag_ff[63:0];
   assign rsp_tag_high = tag_ff[127:64];

endmodule

FILE: sv/poly1305_mac.sv
// Poly1305 one-time authenticator. Load the 256-bit key through the csr port
// (index 0/1: r low/high, clamped inside; index 2/3: s low/high) while the block is
// idle. Each req word is one 16-byte little-endian message block with its byte count
// (0..16, counts above 16 act as 16; bytes past the count are ignored). A block of
// fewer than 16 bytes gets a 0x01 pad byte and no 2^128 bit. req_last_block closes
// the message: the accumulator is fully reduced mod 2^130-5, s is added mod 2^128,
// one rsp word carries the tag, and the accumulator is cleared for the next message.
// A word with zero bytes absorbs nothing; with last set it still yields a tag.
// Steps: a block of 1..16 bytes is accepted, then runs five product rows on the
// five-multiplier row array, the last row sum and the carry fold; a last word adds the
// final reduction and pad add, plus any wait for the rsp register to free up. A
// zero-byte non-last word is done at acceptance; a zero-byte last word runs only the
// final reduction and pad add. One word is in work at a time; a finished tag can sit
// in the rsp register while the next word is absorbed.
module poly1305_mac import p1305_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   // message blocks
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [63:0]          req_block_low,
   input  logic [63:0]          req_block_high,
   input  logic [4:0]           req_valid_bytes,
   input  logic                 req_last_block,
   // tags
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_tag_low,
   output logic [63:0]          rsp_tag_high
);

   p1305_cmd_type cmd;

   // sequencer: row counter, final reduction steps, tag register handshake
   p1305_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_valid_bytes (req_valid_bytes),
      .req_last_block  (req_last_block),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd)
   );

   // key registers, radix 2^26 limb accumulator, multiplier row, reduction and pad add
   p1305_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .req_valid_bytes (req_valid_bytes),
      .cmd             (cmd),
      .rsp_tag_low     (rsp_tag_low),
      .rsp_tag_high    (rsp_tag_high)
   );

endmodule

FILE: sv/p1305_check.sv
module p1305_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [4:0]  req_valid_bytes,
   input logic        req_last_block,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_tag_low,
   input logic [63:0] rsp_tag_high
);

   // stalled tag holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tag_low) && $stable(rsp_tag_high))
      else $error("tag changed while stalled");

   // a word that absorbs or closes a message keeps the input stalled next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_valid_bytes != 5'd0 || req_last_block) |=> req_stall)
      else $error("input not stalled while word in work");

   // an empty non-last word is done at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_valid_bytes == 5'd0 && !req_last_block |=> !req_stall)
      else $error("empty word held the input");

   // a new tag only appears at the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("tag appeared while idle");

endmodule

bind poly1305_mac p1305_check u_check (.*);

FILE: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import p1305_pkg::*;

   // One message block as the sender presents it
   typedef struct packed {
      logic [63:0] block_low;
      logic [63:0] block_high;
      logic [4:0]  valid_bytes;
      logic        last_block;
   } msg_word_type;

   localparam int SETTLE_CYCLES = 16;   // settle time for a non-last block to finish
   localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
   localparam logic [25:0] BIT_128 = 26'd1 << 24;  // 2^128 as seen in limb 4

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_wdata = '0;

   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [63:0] req_block_low   = '0;
   logic [63:0] req_block_high  = '0;
   logic [4:0]  req_valid_bytes = '0;
   logic        req_last_block  = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_tag_low;
   logic [63:0] rsp_tag_high;

   poly1305_mac uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .req_valid_bytes (req_valid_bytes),
      .req_last_block  (req_last_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tag_low     (rsp_tag_low),
      .rsp_tag_high    (rsp_tag_high)
   );

   // Stimulus and expectation stores
   msg_word_type   pending_words[$];   // filled by the sequence, drained by the driver
   logic [127:0]   pending_tags[$];    // tags predicted but not yet seen
   msg_word_type   cur_word;           // word currently on the req port
   int             words_sent  = 0;
   int             words_taken = 0;
   int             mismatch_count = 0;

   // Idling knobs, percent of cycles
   int send_idle_pct = 25;
   int recv_idle_pct = 25;

   // Long hold-off: armed by the sequence, counted by the receiver
   bit hold_armed = 1'b0;
   bit hold_done  = 1'b0;
   int hold_left  = 0;

   // Predictor state: key as the registers hold it, accumulator as 27-bit limbs
   logic [127:0] key_r = '0;
   logic [127:0] key_s = '0;
   logic [26:0]  acc_limb [5] = '{default: '0};

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Add one padded 130-bit block to the accumulator, multiply by clamped r,
   // partial reduction mod 2^130-5. Limbs are 26 bits wide, limb 4 carries
   // the 2^128 bit for a full block.
   function automatic void mul_block(input logic [127:0] m, input logic [25:0] top);
      logic [63:0] rk[5], rk5[5], h[5], d[5];
      rk[0] = key_r[25:0];
      rk[1] = key_r[51:26] & CLAMP_R1;
      rk[2] = key_r[77:52] & CLAMP_R2;
      rk[3] = key_r[103:78] & CLAMP_R3;
      rk[4] = key_r[127:104] & CLAMP_R4;
      for (int i = 0; i < NUM_LIMBS; i++)
         rk5[i] = rk[i] * 5;

      h[0] = acc_limb[0] + m[25:0];
      h[1] = acc_limb[1] + m[51:26];
      h[2] = acc_limb[2] + m[77:52];
      h[3] = acc_limb[3] + m[103:78];
      h[4] = acc_limb[4] + (m[127:104] | top);

      // schoolbook product, wrapped terms folded in with 5*r
      for (int i = 0; i < NUM_LIMBS; i++) begin
         d[i] = '0;
         for (int j = 0; j < NUM_LIMBS; j++)
            d[i] += h[j] * ((i >= j) ? rk[i - j] : rk5[i - j + NUM_LIMBS]);
      end

      d[1] += d[0] >> 26;  h[0] = d[0] & LIMB_MASK;
      d[2] += d[1] >> 26;  h[1] = d[1] & LIMB_MASK;
      d[3] += d[2] >> 26;  h[2] = d[2] & LIMB_MASK;
      d[4] += d[3] >> 26;  h[3] = d[3] & LIMB_MASK;
      h[0] += (d[4] >> 26) * 5;
      h[4] = d[4] & LIMB_MASK;
      h[1] += h[0] >> 26;
      h[0] &= LIMB_MASK;

      for (int i = 0; i < NUM_LIMBS; i++)
         acc_limb[i] = h[i][26:0];
   endfunction

   // Full reduction, conditional subtract of p, then + s mod 2^128.
   // 32-bit wraparound is intended in the subtract step.
   function automatic logic [127:0] final_tag();
      logic [31:0] a0, a1, a2, a3, a4, b0, b1, b2, b3, b4, pick;
      logic [31:0] w0, w1, w2, w3;
      a0 = acc_limb[0];
      a1 = acc_limb[1];
      a2 = acc_limb[2];
      a3 = acc_limb[3];
      a4 = acc_limb[4];

      a2 += a1 >> 26;  a1 &= LIMB_MASK;
      a3 += a2 >> 26;  a2 &= LIMB_MASK;
      a4 += a3 >> 26;  a3 &= LIMB_MASK;
      a0 += (a4 >> 26) * 5;
      a4 &= LIMB_MASK;
      a1 += a0 >> 26;
      a0 &= LIMB_MASK;

      b0 = a0 + 5;
      b1 = a1 + (b0 >> 26);  b0 &= LIMB_MASK;
      b2 = a2 + (b1 >> 26);  b1 &= LIMB_MASK;
      b3 = a3 + (b2 >> 26);  b2 &= LIMB_MASK;
      b4 = a4 + (b3 >> 26) - 32'h400_0000;
      b3 &= LIMB_MASK;

      // all ones when h >= p
      pick = (b4 >> 31) - 32'd1;
      a0 = (a0 & ~pick) | (b0 & pick);
      a1 = (a1 & ~pick) | (b1 & pick);
      a2 = (a2 & ~pick) | (b2 & pick);
      a3 = (a3 & ~pick) | (b3 & pick);
      a4 = (a4 & ~pick) | (b4 & pick);

      // limbs overlap by OR, not add, when a1 carries past bit 26
      w0 = a0 | (a1 << 26);
      w1 = (a1 >> 6) | (a2 << 20);
      w2 = (a2 >> 12) | (a3 << 14);
      w3 = (a3 >> 18) | (a4 << 8);
      return {w3, w2, w1, w0} + key_s;
   endfunction

   // One accepted word: pad and absorb, and on the last word queue the tag
   function automatic void absorb_word(input msg_word_type w);
      logic [127:0] data, keep;
      int n;
      n = (w.valid_bytes > BLOCK_BYTES) ? 16 : int'(w.valid_bytes);
      data = {w.block_high, w.block_low};
      if (n == 16) begin
         mul_block(data, BIT_128);
      end else if (n != 0) begin
         // drop bytes past the count, 0x01 pad byte right after them
         keep = (128'd1 << (8 * n)) - 128'd1;
         mul_block((data & keep) | (128'd1 << (8 * n)), '0);
      end
      if (w.last_block) begin
         pending_tags.push_back(final_tag());
         acc_limb = '{default: '0};
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Driver: a new word goes out only once the current one is taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_word(cur_word);
            words_taken <= words_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_word = pending_words.pop_front();
               req_valid       <= 1'b1;
               req_block_low   <= cur_word.block_low;
               req_block_high  <= cur_word.block_high;
               req_valid_bytes <= cur_word.valid_bytes;
               req_last_block  <= cur_word.last_block;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall, plus one long hold-off when armed
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: each taken tag against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : tag_check
      logic [127:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tags.size() == 0) begin
            flag_mismatch($sformatf("unexpected tag %h_%h", rsp_tag_high, rsp_tag_low));
         end else begin
            want = pending_tags.pop_front();
            if (rsp_tag_low !== want[63:0])
               flag_mismatch($sformatf("tag_low %h, want %h", rsp_tag_low, want[63:0]));
            if (rsp_tag_high !== want[127:64])
               flag_mismatch($sformatf("tag_high %h, want %h", rsp_tag_high, want[127:64]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence helpers
   // ------------------------------------------------------------------
   task automatic queue_word(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] n, input logic last);
      pending_words.push_back('{block_low: lo, block_high: hi, valid_bytes: n,
                                last_block: last});
      words_sent++;
   endtask

   // Block must be idle: the predictor key is updated along with the register
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEY_R_LOW:  key_r[63:0]   = value;
         CSR_KEY_R_HIGH: key_r[127:64] = value;
         CSR_KEY_S_LOW:  key_s[63:0]   = value;
         CSR_KEY_S_HIGH: key_s[127:64] = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_key(input logic [63:0] r_lo, input logic [63:0] r_hi,
                           input logic [63:0] s_lo, input logic [63:0] s_hi);
      write_reg(CSR_KEY_R_LOW, r_lo);
      write_reg(CSR_KEY_R_HIGH, r_hi);
      write_reg(CSR_KEY_S_LOW, s_lo);
      write_reg(CSR_KEY_S_HIGH, s_hi);
   endtask

   // All words taken, all tags seen, then time for a non-last block to finish
   task automatic wait_idle();
      do @(posedge clock);
      while (words_taken != words_sent || pending_tags.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // full block count, now and then an oversize count that acts as 16
   function automatic logic [4:0] full_count();
      if ($urandom_range(0, 15) == 0)
         return 5'($urandom_range(17, 31));
      return BLOCK_BYTES;
   endfunction

   function automatic logic [4:0] tail_count();
      int n;
      n = $urandom_range(0, 20);
      if (n > 16)
         return 5'($urandom_range(17, 31));
      return 5'(n);
   endfunction

   // Mostly whole messages (full blocks then a closing word), some noise:
   // stray short blocks, ignored empty words, fully random words
   task automatic run_messages(input int send_pct, input int recv_pct, input int word_target);
      int sent, nfull;
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < word_target) begin
         if ($urandom_range(0, 9) != 0) begin
            nfull = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                : $urandom_range(4, 12);
            repeat (nfull) queue_word(rand64(), rand64(), full_count(), 1'b0);
            queue_word(rand64(), rand64(), tail_count(), 1'b1);
            sent += nfull + 1;
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  queue_word(rand64(), rand64(), 5'($urandom_range(1, 15)), 1'b0);
                  sent++;
               end
               1: queue_word(rand64(), rand64(), 5'd0, 1'b0);  // no effect, not counted
               default: begin
                  queue_word(rand64(), rand64(), 5'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)));
                  sent++;
               end
            endcase
         end
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // key registers come out of reset as zero: empty message tags to zero
      @(negedge clock);
      queue_word('0, '0, 5'd0, 1'b1);
      wait_idle();

      // all-ones key, edge cases of the byte count and the pad
      load_key('1, '1, '1, '1);
      @(negedge clock);
      queue_word(rand64(), rand64(), 5'd0, 1'b1);      // empty message: s alone
      queue_word('1, '1, BLOCK_BYTES, 1'b0);
      queue_word('1, '1, BLOCK_BYTES, 1'b1);
      queue_word('0, '0, BLOCK_BYTES, 1'b1);
      queue_word('1, '1, 5'd1, 1'b1);                  // junk past the count
      queue_word('1, '1, 5'd15, 1'b1);
      queue_word('1, '1, 5'd7, 1'b0);                  // short block mid message
      queue_word(rand64(), rand64(), BLOCK_BYTES, 1'b0);
      queue_word(rand64(), rand64(), 5'd0, 1'b1);      // zero-byte close
      queue_word(rand64(), rand64(), 5'd0, 1'b0);      // ignored
      queue_word(rand64(), rand64(), 5'd31, 1'b1);     // oversize count
      queue_word(rand64(), rand64(), 5'd17, 1'b0);
      queue_word(rand64(), rand64(), 5'd8, 1'b1);
      wait_idle();

      // r of zero; then writes above the last index must leave the key alone
      load_key('0, '0, rand64(), rand64());
      for (int i = int'(CSR_KEY_S_HIGH) + 1; i < 2 ** CSR_IDX_W; i++)
         write_reg(CSR_IDX_W'(i), '1);
      @(negedge clock);
      queue_word(rand64(), rand64(), BLOCK_BYTES, 1'b0);
      queue_word(rand64(), rand64(), BLOCK_BYTES, 1'b1);
      wait_idle();

      // key changed in the middle of a message
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
      @(negedge clock);
      queue_word(rand64(), rand64(), BLOCK_BYTES, 1'b0);
      wait_idle();
      write_reg(CSR_KEY_R_LOW, {$urandom, $urandom});
      write_reg(CSR_KEY_S_HIGH, {$urandom, $urandom});
      @(negedge clock);
      queue_word(rand64(), rand64(), 5'd5, 1'b1);
      wait_idle();

      // random traffic: slow receiver, then slow sender, then full speed
      for (int k = 0; k < 2; k++) begin
         load_key(rand64(), rand64(), rand64(), rand64());
         run_messages(9, 81, 255);
      end
      for (int k = 0; k < 2; k++) begin
         load_key(rand64(), rand64(), rand64(), rand64());
         run_messages(81, 9, 255);
      end
      load_key(rand64(), rand64(), rand64(), rand64());
      @(negedge clock);
      hold_armed = 1'b1;    // receiver backs off while the sender keeps going
      run_messages(0, 0, 255);
      load_key('1, rand64(), rand64(), '1);
      run_messages(0, 0, 255);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: files.f
sv/p1305_pkg.sv
sv/p1305_ctrl.sv
sv/p1305_dpath.sv
sv/poly1305_mac.sv
sv/p1305_check.sv
test/tb_top.sv
